>>> rtl/spf_pkg.sv
// Shared types and constants of the spectral peak frequency finder.
package spf_pkg;

  localparam int MAX_FFT_SIZE_DEF = 65536;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // configuration register widths and reset values
  localparam int SR_W   = 18;
  localparam int FS_W   = 17;
  localparam int MM_W   = 32;
  localparam logic [SR_W-1:0] SRATE_RESET  = 18'd48000;
  localparam logic [FS_W-1:0] FSIZE_RESET  = 17'd1024;
  localparam logic [MM_W-1:0] MINMAG_RESET = 32'd0;

  // sample rate scaled by 256 (8 fraction bits)
  localparam int S_W = SR_W + 8;

  // result field widths
  localparam int FREQ_W = 25;
  localparam int PBIN_W = 16;
  localparam int PPOW_W = 32;
  localparam int OUT_W  = 2 + PBIN_W + PPOW_W + FREQ_W;
  localparam int OUT_DW = ((OUT_W + 7) / 8) * 8;
  localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FFT_SIZE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_MAG     = 2'd2;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } iter_op_e;

  typedef struct packed {
    logic sq_re;
    logic sq_im;
    logic upd;
    logic clear;
  } trk_ctrl_t;

  // result beat, found in bit 0
  typedef struct packed {
    logic [OUT_DW-OUT_W-1:0] pad;
    logic [FREQ_W-1:0]       frequency_q8;
    logic [PPOW_W-1:0]       peak_power;
    logic [PBIN_W-1:0]       peak_bin;
    logic                    fit_ok;
    logic                    found;
  } out_beat_t;

endpackage

>>> rtl/spf_iter.sv
// Shared shift-add multiplier / restoring divider, one bit per cycle.
module spf_iter import spf_pkg::*; #(
  parameter int W  = 58,
  parameter int NW = $clog2(W + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  iter_op_e      op_i,
  input  logic [W-1:0]  opa_i,   // multiplicand or divisor
  input  logic [W-1:0]  opb_i,   // multiplier (msb aligned) or dividend
  input  logic [NW-1:0] steps_i,
  output logic          busy_o,
  output logic [W-1:0]  acc_o,   // product or remainder
  output logic [W-1:0]  quo_o    // quotient
);

  logic [W:0]    acc_q, acc_d;
  logic [W-1:0]  shr_q, shr_d;
  logic [W-1:0]  opa_q;
  iter_op_e      op_q;
  logic [NW-1:0] cnt_q;
  logic          busy_q;

  logic [W:0]    shifted;
  logic [W:0]    addend;
  logic          cin;
  logic [W+1:0]  sum;
  logic          take;

  always_comb begin
    shifted = {acc_q[W-1:0], (op_q == OP_DIV) ? shr_q[W-1] : 1'b0};
    if (op_q == OP_DIV) begin
      addend = ~{1'b0, opa_q};
      cin    = 1'b1;
    end else begin
      addend = shr_q[W-1] ? {1'b0, opa_q} : '0;
      cin    = 1'b0;
    end
    sum  = {1'b0, shifted} + {1'b0, addend} + (W+2)'(cin);
    take = sum[W+1];  // no borrow on subtract
    if (op_q == OP_DIV) begin
      acc_d = take ? sum[W:0] : shifted;
      shr_d = {shr_q[W-2:0], take};
    end else begin
      acc_d = sum[W:0];
      shr_d = {shr_q[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= steps_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - NW'(1);
      if (cnt_q == NW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      shr_q <= opb_i;
      opa_q <= opa_i;
      op_q  <= op_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      shr_q <= shr_d;
    end
  end

  assign busy_o = busy_q;
  assign acc_o  = acc_q[W-1:0];
  assign quo_o  = shr_q;

endmodule

>>> rtl/spf_track.sv
// Bin power and running peak tracker with neighbor capture.
module spf_track import spf_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int MAX_FFT_SIZE = MAX_FFT_SIZE_DEF,
  parameter int PW           = 2 * SAMPLE_WIDTH,
  parameter int CW           = $clog2(MAX_FFT_SIZE / 2 + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  trk_ctrl_t                      ctrl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] re_i,
  input  logic signed [SAMPLE_WIDTH-1:0] im_i,
  input  logic                           last_i,
  input  logic [MM_W-1:0]                min_mag_i,
  output logic [PW-1:0]                  best_power_o,
  output logic [CW-1:0]                  best_index_o,
  output logic [PW-1:0]                  left_power_o,
  output logic [PW-1:0]                  right_power_o
);

  localparam int HALF  = MAX_FFT_SIZE / 2;
  localparam int CMP_W = (PW > MM_W) ? PW : MM_W;

  logic signed [SAMPLE_WIDTH-1:0] mul_op;
  logic signed [PW-1:0]           sq;
  logic [PW-1:0] prod_q, lo_q;
  logic [PW-1:0] p, e;
  logic [CW-1:0] cnt_q;
  logic [PW-1:0] prev_q, best_q, left_q, right_q;
  logic [CW-1:0] idx_q;
  logic          cap_q;

  // one squarer, real part first then imaginary
  assign mul_op = ctrl_i.sq_im ? im_i : re_i;
  assign sq     = mul_op * mul_op;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sq_re) begin
      prod_q <= sq;
    end
    if (ctrl_i.sq_im) begin
      lo_q   <= prod_q;
      prod_q <= sq;
    end
  end

  always_comb begin
    p = lo_q + prod_q;
    if (cnt_q == '0 || last_i || CMP_W'(p) <= CMP_W'(min_mag_i)) begin
      e = '0;
    end else begin
      e = p;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      prev_q  <= '0;
      best_q  <= '0;
      idx_q   <= '0;
      left_q  <= '0;
      right_q <= '0;
      cap_q   <= 1'b0;
    end else if (ctrl_i.clear) begin
      cnt_q   <= '0;
      prev_q  <= '0;
      best_q  <= '0;
      idx_q   <= '0;
      left_q  <= '0;
      right_q <= '0;
      cap_q   <= 1'b0;
    end else if (ctrl_i.upd) begin
      if (e > best_q) begin
        best_q <= e;
        idx_q  <= cnt_q;
        left_q <= prev_q;
        cap_q  <= 1'b1;
      end else if (cap_q) begin
        right_q <= e;
        cap_q   <= 1'b0;
      end
      prev_q <= e;
      if (cnt_q < CW'(HALF)) begin
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  assign best_power_o  = best_q;
  assign best_index_o  = idx_q;
  assign left_power_o  = left_q;
  assign right_power_o = right_q;

endmodule

>>> rtl/spectral_peak_frequency_finder_unit.sv
// Top level: stream ports, configuration, frame sequencer and result register.
//
// Usage. FFT bins enter on the s_axis group, one beat per bin from DC up to
// the Nyquist bin, which carries s_axis_tlast. tdata holds bin_real in the
// low SAMPLE_WIDTH bits and bin_imag above it. Each bin passes through the
// accept state, real then imaginary on the single squarer, and a tracker update.
// The beat with tlast closes the frame and yields one result beat on m_axis.
// The frame end runs the shared shift/add unit one bit per cycle:
// |num|*S (26 steps), /2D (W steps), k*S (CW steps), T/fft_size (W steps),
// with W = max(2*SAMPLE_WIDTH, CW) + 26 and CW = clog2(MAX_FFT_SIZE/2+1). From
// the tracker update of the last bin the result is registered after the fit
// state and these runs, without the first two when no fit is needed and
// without any when no peak was found. s_axis_tready is high only while the
// sequencer is idle.
// A single output register holds the result; a new frame may stream in while
// it waits. If the receiver still stalls when the next frame ends, the block
// holds that result and takes no bins until the register frees.
// Configuration writes (cfg_*) are taken every cycle and must only occur
// while the block is idle. Reset restores register defaults (48000 Hz,
// 1024 points, threshold 0) and clears the frame state.
module spectral_peak_frequency_finder_unit import spf_pkg::*; #(
  parameter int MAX_FFT_SIZE = MAX_FFT_SIZE_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  // bins: [SAMPLE_WIDTH-1:0] bin_real, [2*SAMPLE_WIDTH-1:SAMPLE_WIDTH] bin_imag
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
  input  logic                                      s_axis_tlast,
  // result: [0] found, [1] fit_ok, [17:2] peak_bin, [49:18] peak_power,
  //         [74:50] frequency_q8, [79:75] zero
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  output logic [OUT_DW-1:0]                         m_axis_tdata,
  // configuration writes
  input  logic                                      cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]                      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]                     cfg_data_i
);

  localparam int PW = 2 * SAMPLE_WIDTH;                  // bin power
  localparam int CW = $clog2(MAX_FFT_SIZE / 2 + 1);      // bin index
  localparam int DW = PW + 3;                            // signed fit terms
  localparam int TW = CW + S_W;                          // k*S + offset
  localparam int W  = (PW + S_W > TW) ? PW + S_W : TW;   // shared unit
  localparam int NW = $clog2(W + 1);

  // sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SQRE  = 4'd1;
  localparam logic [3:0] ST_SQIM  = 4'd2;
  localparam logic [3:0] ST_UPD   = 4'd3;
  localparam logic [3:0] ST_FIT   = 4'd4;
  localparam logic [3:0] ST_MUL1  = 4'd5;
  localparam logic [3:0] ST_MUL1W = 4'd6;
  localparam logic [3:0] ST_DIV1  = 4'd7;
  localparam logic [3:0] ST_DIV1W = 4'd8;
  localparam logic [3:0] ST_MUL2  = 4'd9;
  localparam logic [3:0] ST_MUL2W = 4'd10;
  localparam logic [3:0] ST_SUMT  = 4'd11;
  localparam logic [3:0] ST_DIV2  = 4'd12;
  localparam logic [3:0] ST_DIV2W = 4'd13;
  localparam logic [3:0] ST_RES   = 4'd14;

  logic [3:0] state_q, state_d;

  // configuration registers
  logic [SR_W-1:0] srate_q;
  logic [FS_W-1:0] fsize_q;
  logic [MM_W-1:0] minmag_q;
  logic [S_W-1:0]  s_scaled;

  // captured bin
  logic signed [SAMPLE_WIDTH-1:0] re_q, im_q;
  logic                           last_q;
  logic                           in_fire;

  // tracker
  trk_ctrl_t     trk_ctrl;
  logic [PW-1:0] trk_best, trk_left, trk_right;
  logic [CW-1:0] trk_idx;

  // fit terms latched at frame end
  logic signed [DW-1:0] fa_s, fb_s, fc_s, d_s, num_s, mag_s;
  logic                 found_c, ok_c, fit_c;
  logic                 found_q, ok_q, neg_q;
  logic [PW-1:0]        mag_q;
  logic [DW-1:0]        d2_q;
  logic [CW-1:0]        k_q;
  logic [PPOW_W-1:0]    ppow_q;
  logic [S_W-1:0]       q_q;
  logic [TW-1:0]        t_q, prod2;
  logic [FREQ_W-1:0]    freq_q;

  // shared unit
  logic          it_start, it_busy;
  iter_op_e      it_op;
  logic [W-1:0]  it_opa, it_opb, it_acc, it_quo;
  logic [NW-1:0] it_steps;

  // output register
  logic      m_valid_q;
  out_beat_t m_data_q, beat;
  logic      out_free;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_scaled      = {srate_q, 8'd0};
  assign out_free      = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srate_q  <= SRATE_RESET;
      fsize_q  <= FSIZE_RESET;
      minmag_q <= MINMAG_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SAMPLE_RATE: srate_q  <= cfg_data_i[SR_W-1:0];
        REG_FFT_SIZE:    fsize_q  <= cfg_data_i[FS_W-1:0];
        REG_MIN_MAG:     minmag_q <= cfg_data_i[MM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      re_q   <= s_axis_tdata[SAMPLE_WIDTH-1:0];
      im_q   <= s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
      last_q <= s_axis_tlast;
    end
  end

  always_comb begin
    trk_ctrl       = '0;
    trk_ctrl.sq_re = (state_q == ST_SQRE);
    trk_ctrl.sq_im = (state_q == ST_SQIM);
    trk_ctrl.upd   = (state_q == ST_UPD);
    trk_ctrl.clear = (state_q == ST_FIT);  // terms are latched in the same cycle
  end

  spf_track #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .MAX_FFT_SIZE(MAX_FFT_SIZE),
    .PW          (PW),
    .CW          (CW)
  ) u_track (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (trk_ctrl),
    .re_i         (re_q),
    .im_i         (im_q),
    .last_i       (last_q),
    .min_mag_i    (minmag_q),
    .best_power_o (trk_best),
    .best_index_o (trk_idx),
    .left_power_o (trk_left),
    .right_power_o(trk_right)
  );

  // parabola terms: D = 2fb - fa - fc, num = fc - fa
  always_comb begin
    fa_s    = $signed(DW'(trk_left));
    fb_s    = $signed(DW'(trk_best));
    fc_s    = $signed(DW'(trk_right));
    d_s     = (fb_s <<< 1) - fa_s - fc_s;
    num_s   = fc_s - fa_s;
    mag_s   = (num_s < 0) ? -num_s : num_s;
    found_c = (trk_best != '0);
    ok_c    = found_c && (num_s >= -d_s) && (num_s < d_s);
    fit_c   = ok_c && (d_s > 0) && (num_s != 0);
  end

  // shared unit operands
  always_comb begin
    it_start = 1'b0;
    it_op    = OP_DIV;
    it_opa   = '0;
    it_opb   = '0;
    it_steps = NW'(W);
    unique case (state_q)
      ST_MUL1: begin
        it_start = 1'b1;
        it_op    = OP_MUL;
        it_opa   = W'(mag_q);
        it_opb   = {s_scaled, {(W-S_W){1'b0}}};
        it_steps = NW'(S_W);
      end
      ST_DIV1: begin
        it_start = 1'b1;
        it_opa   = W'(d2_q);
        it_opb   = it_acc;
      end
      ST_MUL2: begin
        it_start = 1'b1;
        it_op    = OP_MUL;
        it_opa   = W'(s_scaled);
        it_opb   = {k_q, {(W-CW){1'b0}}};
        it_steps = NW'(CW);
      end
      ST_DIV2: begin
        it_start = 1'b1;
        it_opa   = W'(fsize_q);
        it_opb   = W'(t_q);
      end
      default: ;
    endcase
  end

  spf_iter #(
    .W (W),
    .NW(NW)
  ) u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(it_start),
    .op_i   (it_op),
    .opa_i  (it_opa),
    .opb_i  (it_opb),
    .steps_i(it_steps),
    .busy_o (it_busy),
    .acc_o  (it_acc),
    .quo_o  (it_quo)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_fire) state_d = ST_SQRE;
      ST_SQRE:  state_d = ST_SQIM;
      ST_SQIM:  state_d = ST_UPD;
      ST_UPD:   state_d = last_q ? ST_FIT : ST_IDLE;
      ST_FIT: begin
        if (!found_c) begin
          state_d = ST_RES;
        end else if (fit_c) begin
          state_d = ST_MUL1;
        end else begin
          state_d = ST_MUL2;
        end
      end
      ST_MUL1:  state_d = ST_MUL1W;
      ST_MUL1W: if (!it_busy) state_d = ST_DIV1;
      ST_DIV1:  state_d = ST_DIV1W;
      ST_DIV1W: if (!it_busy) state_d = ST_MUL2;
      ST_MUL2:  state_d = ST_MUL2W;
      ST_MUL2W: if (!it_busy) state_d = ST_SUMT;
      ST_SUMT:  state_d = ST_DIV2;
      ST_DIV2:  state_d = ST_DIV2W;
      ST_DIV2W: if (!it_busy) state_d = ST_RES;
      ST_RES:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign prod2 = it_acc[TW-1:0];

  // frame-end datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_FIT: begin
        found_q <= found_c;
        ok_q    <= ok_c;
        neg_q   <= (num_s < 0);
        mag_q   <= mag_s[PW-1:0];
        d2_q    <= d_s << 1;
        k_q     <= trk_idx;
        ppow_q  <= PPOW_W'(trk_best);
        q_q     <= '0;
        freq_q  <= '0;
      end
      ST_DIV1W: begin
        // negative offset rounds toward minus infinity
        if (!it_busy) begin
          q_q <= it_quo[S_W-1:0] + S_W'(neg_q && (it_acc != '0));
        end
      end
      ST_SUMT: begin
        t_q <= neg_q ? prod2 - TW'(q_q) : prod2 + TW'(q_q);
      end
      ST_DIV2W: begin
        if (!it_busy) begin
          freq_q <= (|it_quo[W-1:FREQ_W]) ? FREQ_MAX : it_quo[FREQ_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    beat              = '0;
    beat.found        = found_q;
    beat.fit_ok       = found_q && ok_q;
    beat.peak_bin     = found_q ? PBIN_W'(k_q) : '0;
    beat.peak_power   = found_q ? ppow_q : '0;
    beat.frequency_q8 = found_q ? freq_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (state_q == ST_RES && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RES && out_free) begin
      m_data_q <= beat;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

>>> test/spectral_peak_frequency_finder_unit_tb.sv
// Self-checking stream testbench for the spectral peak frequency finder.
module spectral_peak_frequency_finder_unit_tb;
  import spf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_BINS    = MAX_FFT_SIZE_DEF / 2;
  // Wait for the frame-end sequence to settle; leave margin on top.
  localparam int DRAIN_CYCLES = 200;
  // Longest quiet stretch: receiver hold-off plus a slow fit, with room to spare.
  localparam int WATCHDOG_MAX = 20000;
  // Long receiver hold-off, triggered once after a few results.
  localparam int HOLD_AT      = 12;
  localparam int HOLD_LEN     = 2000;
  localparam int PHASE_BINS   = 175;
  localparam int NUM_PHASES   = 8;
  // Index with no register behind it; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               last;
  } bin_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [31:0]           s_axis_tdata  = '0;   // [15:0] bin_real, [31:16] bin_imag
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DW-1:0]     m_axis_tdata;         // found, fit_ok, peak_bin, peak_power, freq
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  spectral_peak_frequency_finder_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shared bookkeeping
  // ---------------------------------------------------------------------------
  bin_t      pending_bins[$];    // bins not yet put on the bus
  out_beat_t expected_peaks[$];  // predicted result beats, oldest first
  int        bins_queued   = 0;
  int        bins_taken    = 0;
  int        peaks_seen    = 0;
  int        mismatches    = 0;
  int        quiet_cycles  = 0;
  bit        idle_on       = 1'b1;  // random bubbles on both sides
  int        src_gap       = 0;
  int        sink_gap      = 0;
  int        hold_left     = 0;
  bit        hold_done     = 1'b0;

  // Shadow of the configuration registers
  logic [SR_W-1:0] rate_q  = SRATE_RESET;
  logic [FS_W-1:0] size_q  = FSIZE_RESET;
  logic [MM_W-1:0] floor_q = MINMAG_RESET;

  // Shadow of the frame tracker
  logic [15:0] trk_idx      = '0;  // index of the next bin, saturating
  logic [31:0] trk_prev     = '0;  // power of the previous bin, 0 if skipped
  logic [31:0] trk_best     = '0;
  logic [15:0] trk_best_idx = '0;
  logic [31:0] trk_left     = '0;
  logic [31:0] trk_right    = '0;
  logic        trk_cap      = 1'b0; // waiting for the bin right of the best

  // ---------------------------------------------------------------------------
  // Peak predictor: one call per accepted bin; on the closing bin it pushes
  // the expected result beat and clears the frame.
  // ---------------------------------------------------------------------------
  task automatic track_bin(input bin_t b);
    longint    pw, fa, fb, fc, d, num, s, t, prod, q, rem, freq;
    out_beat_t r;
    pw = longint'(b.re) * longint'(b.re) + longint'(b.im) * longint'(b.im);
    // DC, the Nyquist bin and anything at or below threshold never compete
    if (trk_idx == 0 || b.last || pw <= {32'd0, floor_q}) pw = 0;
    // strictly greater: on a tie the first peak stays
    if (pw > {32'd0, trk_best}) begin
      trk_best     = pw[31:0];
      trk_best_idx = trk_idx;
      trk_left     = trk_prev;
      trk_cap      = 1'b1;
    end else if (trk_cap) begin
      trk_right = pw[31:0];
      trk_cap   = 1'b0;
    end
    trk_prev = pw[31:0];
    if (trk_idx < HALF_BINS) trk_idx++;
    if (b.last) begin
      r = '0;
      if (trk_best != 0) begin
        fa   = trk_left;
        fb   = trk_best;
        fc   = trk_right;
        d    = 2 * fb - fa - fc;
        num  = fc - fa;
        s    = rate_q;
        s    = s * 256;
        t    = s * longint'(trk_best_idx);
        r.found    = 1'b1;
        r.fit_ok   = (num >= -d) && (num < d);
        // failed fit falls back to the plain bin frequency
        if (r.fit_ok && d > 0 && num != 0) begin
          prod = (num < 0) ? -num : num;
          prod = prod * s;
          q    = prod / (2 * d);
          rem  = prod % (2 * d);
          if (num > 0) begin
            t = t + q;
          end else begin
            if (rem != 0) q++;  // floor toward minus infinity
            t = t - q;
          end
        end
        if (size_q == 0) begin
          freq = FREQ_MAX;
        end else begin
          freq = t / longint'(size_q);
          if (freq > longint'(FREQ_MAX)) freq = FREQ_MAX;
        end
        r.peak_bin     = trk_best_idx;
        r.peak_power   = trk_best;
        r.frequency_q8 = freq[FREQ_W-1:0];
      end
      expected_peaks.push_back(r);
      trk_idx      = '0;
      trk_prev     = '0;
      trk_best     = '0;
      trk_best_idx = '0;
      trk_left     = '0;
      trk_right    = '0;
      trk_cap      = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Bin source: feeds pending_bins onto s_axis, holding a beat until taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : source
    bin_t b;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (src_gap == 0 && idle_on && $urandom_range(0, 7) == 0)
        src_gap = $urandom_range(1, 7);
      if (src_gap != 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_bins.size() != 0) begin
        b = pending_bins.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b.im, b.re};
        s_axis_tlast  <= b.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: random back-pressure plus one long hold-off so that the
  // output register and the frame behind it fill and s_axis_tready drops.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : sink
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (!hold_done && peaks_seen >= HOLD_AT) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (sink_gap == 0 && idle_on && $urandom_range(0, 7) == 0)
        sink_gap = $urandom_range(1, 7);
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: tracks config writes, predicts from accepted bins, checks result
  // beats against the oldest prediction, and runs the watchdog.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    out_beat_t got, want;
    bin_t      b;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_SAMPLE_RATE: rate_q  = cfg_data_i[SR_W-1:0];
          REG_FFT_SIZE:    size_q  = cfg_data_i[FS_W-1:0];
          REG_MIN_MAG:     floor_q = cfg_data_i[MM_W-1:0];
          default: ;
        endcase
      end
      // results first: a beat leaving now belongs to an earlier frame
      if (m_axis_tvalid && m_axis_tready) begin
        peaks_seen++;
        got = m_axis_tdata;
        if (expected_peaks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h", m_axis_tdata);
        end else begin
          want = expected_peaks.pop_front();
          if (got.found !== want.found || got.fit_ok !== want.fit_ok ||
              got.peak_bin !== want.peak_bin || got.peak_power !== want.peak_power ||
              got.frequency_q8 !== want.frequency_q8) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result %0d: exp found=%0d ok=%0d bin=%0d pow=%0d freq=%0d",
                        " | got found=%0d ok=%0d bin=%0d pow=%0d freq=%0d"},
                       peaks_seen, want.found, want.fit_ok, want.peak_bin, want.peak_power,
                       want.frequency_q8, got.found, got.fit_ok, got.peak_bin,
                       got.peak_power, got.frequency_q8);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        b.re   = s_axis_tdata[15:0];
        b.im   = s_axis_tdata[31:16];
        b.last = s_axis_tlast;
        track_bin(b);
        bins_taken++;
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("watchdog: no beat for %0d cycles", quiet_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_bin(input int re, input int im, input bit last);
    bin_t b;
    b.re   = re[15:0];
    b.im   = im[15:0];
    b.last = last;
    pending_bins.push_back(b);
    bins_queued++;
  endtask

  // full-range sample biased toward the extremes
  function automatic int rand_sample();
    logic signed [15:0] v;
    case ($urandom_range(0, 7))
      0:       v = -16'sd32768;
      1:       v = 16'sd32767;
      2:       v = '0;
      3:       v = 16'(int'($urandom_range(0, 16)) - 8);
      default: v = 16'($urandom());
    endcase
    return v;
  endfunction

  // Mostly frames with a shaped peak so the fit path gets exercised; the rest
  // are fully random, near-silent, or cut to one or two bins.
  task automatic gen_frame(input int max_len);
    int n, k, kind, pk_re, pk_im, sh;
    kind  = $urandom_range(0, 9);
    n     = (kind == 9) ? $urandom_range(1, 2) : $urandom_range(3, max_len);
    k     = $urandom_range(1, (n > 2) ? n - 2 : 1);
    pk_re = rand_sample();
    pk_im = rand_sample();
    for (int i = 0; i < n; i++) begin
      if (kind <= 5 && i == k) begin
        push_bin(pk_re, pk_im, i == n - 1);
      end else if (kind <= 5 && (i == k - 1 || i == k + 1)) begin
        sh = $urandom_range(0, 4);
        push_bin((pk_re >>> sh) + $urandom_range(0, 6) - 3,
                 (pk_im >>> sh) + $urandom_range(0, 6) - 3, i == n - 1);
      end else if (kind == 6 || kind == 7) begin
        push_bin(rand_sample(), rand_sample(), i == n - 1);
      end else begin
        push_bin($urandom_range(0, 40) - 20, $urandom_range(0, 40) - 20, i == n - 1);
      end
    end
  endtask

  // Called at a rising edge; leaves cfg_valid_i high for a following write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Every bin taken, every result back, then let the frame-end pipeline settle.
  task automatic wait_drained();
    while (bins_taken != bins_queued || expected_peaks.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int base;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames at the reset configuration.
    // one-bin frame: last on DC, nothing found
    push_bin(32767, -32768, 1'b1);
    // silence: zero power never passes a zero threshold
    push_bin(0, 0, 1'b0);
    push_bin(0, 0, 1'b0);
    push_bin(0, 0, 1'b1);
    // extremes: loud DC and Nyquist are ignored, full-scale peak at bin 2
    push_bin(-32768, -32768, 1'b0);
    push_bin(1, 0, 1'b0);
    push_bin(-32768, -32768, 1'b0);
    push_bin(32767, -32768, 1'b0);
    push_bin(-1, -1, 1'b0);
    push_bin(-32768, -32768, 1'b1);
    // ties: first of equal peaks wins, equal right neighbour fails the fit
    push_bin(0, 0, 1'b0);
    push_bin(3, 4, 1'b0);
    push_bin(100, 0, 1'b0);
    push_bin(0, 100, 1'b0);
    push_bin(60, 80, 1'b0);
    push_bin(7, 7, 1'b1);
    // left-leaning peak: negative offset
    push_bin(0, 0, 1'b0);
    push_bin(0, -50, 1'b0);
    push_bin(-200, 0, 1'b0);
    push_bin(20, 0, 1'b0);
    push_bin(0, 0, 1'b1);
    wait_drained();

    // Random phases, each with its own configuration.
    for (int p = 1; p <= NUM_PHASES; p++) begin
      if (p == NUM_PHASES) idle_on = 1'b0;  // clean stretch at the end
      case (p)
        1: begin  // lowest rate, smallest frame; unused index must be harmless
          write_reg(REG_SAMPLE_RATE, 32'd1);
          write_reg(REG_FFT_SIZE, 32'd4);
          write_reg(REG_MIN_MAG, 32'd0);
          write_reg(REG_UNUSED, $urandom());
        end
        2: begin  // threshold at full-scale power: nothing can be found
          write_reg(REG_SAMPLE_RATE, 32'd192000);
          write_reg(REG_FFT_SIZE, 32'd65536);
          write_reg(REG_MIN_MAG, 32'h8000_0000);
        end
        3: begin  // high rate over a tiny frame: frequency saturates at higher bins
          write_reg(REG_SAMPLE_RATE, 32'd192000);
          write_reg(REG_FFT_SIZE, 32'd4);
          write_reg(REG_MIN_MAG, $urandom_range(0, 1 << 20));
        end
        4: begin  // zero frame length saturates the frequency
          write_reg(REG_SAMPLE_RATE, 32'd48000);
          write_reg(REG_FFT_SIZE, 32'd0);
          write_reg(REG_MIN_MAG, 32'd0);
        end
        5: begin  // all-ones writes: registers keep only their own width
          write_reg(REG_SAMPLE_RATE, 32'hFFFF_FFFF);
          write_reg(REG_FFT_SIZE, 32'hFFFF_FFFF);
          write_reg(REG_MIN_MAG, $urandom_range(0, 1 << 24));
        end
        6: begin
          write_reg(REG_SAMPLE_RATE, 32'd48000);
          write_reg(REG_FFT_SIZE, 32'd65536);
          write_reg(REG_MIN_MAG, 32'd0);
        end
        7: begin
          write_reg(REG_SAMPLE_RATE, $urandom_range(1, 192000));
          write_reg(REG_FFT_SIZE, $urandom_range(4, 65536));
          write_reg(REG_MIN_MAG, $urandom_range(0, 1 << 16));
        end
        default: begin
          write_reg(REG_SAMPLE_RATE, $urandom_range(8000, 96000));
          write_reg(REG_FFT_SIZE, 32'd1 << $urandom_range(2, 16));
          write_reg(REG_MIN_MAG, $urandom_range(0, 255));
        end
      endcase
      cfg_valid_i <= 1'b0;
      base = bins_queued;
      // short frames in the first phase so the long hold-off backs up the input
      while (bins_queued - base < PHASE_BINS) gen_frame((p == 1) ? 12 : 40);
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/spf_pkg.sv
rtl/spf_iter.sv
rtl/spf_track.sv
rtl/spectral_peak_frequency_finder_unit.sv
test/spectral_peak_frequency_finder_unit_tb.sv
